[hw/rtl/spmb_pkg.sv]
// Shared types and constants for the skin pixel mask and bounding box block.
package spmb_pkg;

    localparam int PIX_W      = 8;
    localparam int BOX_W      = 11;
    localparam int SIZE_W     = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    // Chroma coefficients, 16 fractional bits
    localparam int COEF_W   = 16;
    localparam int PROD_W   = PIX_W + COEF_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam logic [COEF_W-1:0] K_CB_R = 16'd11059;
    localparam logic [COEF_W-1:0] K_CB_G = 16'd21712;
    localparam logic [COEF_W-1:0] K_CR_G = 16'd27440;
    localparam logic [COEF_W-1:0] K_CR_B = 16'd5328;
    localparam logic [COEF_W-1:0] K_HALF = 16'd32768;
    localparam logic [PIX_W-1:0]  K_OFFSET = 8'd128;

    localparam logic [SIZE_W-1:0] WIDTH_RST    = 12'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RST   = 12'd480;
    localparam logic [PIX_W-1:0]  CB_LOWER_RST = 8'd80;
    localparam logic [PIX_W-1:0]  CB_UPPER_RST = 8'd140;
    localparam logic [PIX_W-1:0]  CR_LOWER_RST = 8'd140;
    localparam logic [PIX_W-1:0]  CR_UPPER_RST = 8'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_CB_LOWER     = 3'd2,
        CFG_CB_UPPER     = 3'd3,
        CFG_CR_LOWER     = 3'd4,
        CFG_CR_UPPER     = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_blue;
        logic [PIX_W-1:0] pixel_green;
        logic [PIX_W-1:0] pixel_red;
    } t_pixel;

    typedef struct packed {
        logic [PIX_W-1:0] cb_lower;
        logic [PIX_W-1:0] cb_upper;
        logic [PIX_W-1:0] cr_lower;
        logic [PIX_W-1:0] cr_upper;
    } t_window;

    typedef struct packed {
        logic             frame_done;
        logic             box_found;
        logic [BOX_W-1:0] box_left;
        logic [BOX_W-1:0] box_top;
        logic [BOX_W-1:0] box_right;
        logic [BOX_W-1:0] box_bottom;
    } t_box_info;

    typedef struct packed {
        logic [PIX_W-1:0] masked_blue;
        logic [PIX_W-1:0] masked_green;
        logic [PIX_W-1:0] masked_red;
        logic             is_skin;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
        logic             frame_done;
        logic             box_found;
        logic [BOX_W-1:0] box_left;
        logic [BOX_W-1:0] box_top;
        logic [BOX_W-1:0] box_right;
        logic [BOX_W-1:0] box_bottom;
    } t_result;

endpackage

[hw/rtl/spmb_pix_if.sv]
// Pixel input channel: valid/ready handshake carrying one BGR pixel per beat.
interface spmb_pix_if;
    logic                  valid;
    logic                  ready;
    spmb_pkg::t_pixel      data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/spmb_res_if.sv]
// Result channel: valid/ready handshake carrying one masked pixel and box report per beat.
interface spmb_res_if;
    logic                  valid;
    logic                  ready;
    spmb_pkg::t_result     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/spmb_chroma.sv]
// Cb/Cr conversion of one pixel and the chroma window skin test.
module spmb_chroma (
    input  spmb_pkg::t_pixel            i_pix,
    input  spmb_pkg::t_window           i_win,
    output logic [spmb_pkg::PIX_W-1:0]  o_cb,
    output logic [spmb_pkg::PIX_W-1:0]  o_cr,
    output logic                        o_skin
);
    localparam int PW = spmb_pkg::PROD_W;
    localparam int SW = spmb_pkg::SUM_W;
    localparam int QW = SW - spmb_pkg::COEF_W;

    logic [PW-1:0] cb_pos, cb_neg, cr_pos, cr_neg;

    // positive terms carry the +128 offset in the upper byte
    assign cb_pos = PW'(i_pix.pixel_blue * spmb_pkg::K_HALF)
                  + {spmb_pkg::K_OFFSET, spmb_pkg::COEF_W'(0)};
    assign cr_pos = PW'(i_pix.pixel_red * spmb_pkg::K_HALF)
                  + {spmb_pkg::K_OFFSET, spmb_pkg::COEF_W'(0)};
    assign cb_neg = PW'(i_pix.pixel_red * spmb_pkg::K_CB_R)
                  + PW'(i_pix.pixel_green * spmb_pkg::K_CB_G);
    assign cr_neg = PW'(i_pix.pixel_green * spmb_pkg::K_CR_G)
                  + PW'(i_pix.pixel_blue * spmb_pkg::K_CR_B);

    function automatic logic [spmb_pkg::PIX_W-1:0] to_byte(
        input logic [PW-1:0] pos,
        input logic [PW-1:0] neg
    );
        logic signed [SW-1:0] d;
        logic        [QW-1:0] q;
        d = $signed({2'b00, pos}) - $signed({2'b00, neg});
        q = d[SW-1:spmb_pkg::COEF_W];
        if (d <= 0) begin
            to_byte = '0;
        end else if (q > QW'(255)) begin
            to_byte = '1;
        end else begin
            to_byte = q[spmb_pkg::PIX_W-1:0];
        end
    endfunction

    always_comb begin
        o_cb   = to_byte(cb_pos, cb_neg);
        o_cr   = to_byte(cr_pos, cr_neg);
        o_skin = (o_cb > i_win.cb_lower) && (o_cb < i_win.cb_upper)
              && (o_cr > i_win.cr_lower) && (o_cr < i_win.cr_upper);
    end

endmodule

[hw/rtl/spmb_box.sv]
// Column/row counters and the per-frame bounding box of skin pixels.
module spmb_box #(
    parameter int MAX_WIDTH  = spmb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = spmb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_skin,
    input  logic [spmb_pkg::SIZE_W-1:0]   i_width,
    input  logic [spmb_pkg::SIZE_W-1:0]   i_height,
    output spmb_pkg::t_box_info           o_box
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WLW = ($clog2(MAX_WIDTH + 1) > spmb_pkg::SIZE_W)
                       ? $clog2(MAX_WIDTH + 1) : spmb_pkg::SIZE_W;
    localparam int HLW = ($clog2(MAX_HEIGHT + 1) > spmb_pkg::SIZE_W)
                       ? $clog2(MAX_HEIGHT + 1) : spmb_pkg::SIZE_W;
    localparam int BW  = spmb_pkg::BOX_W;
    localparam int EXC = (CW > BW) ? CW : BW;
    localparam int EXR = (RW > BW) ? RW : BW;

    logic [CW-1:0] r_col, n_col, r_lc, n_lc, r_gc, n_gc, upd_lc, upd_gc, last_col;
    logic [RW-1:0] r_row, n_row, r_lr, n_lr, r_gr, n_gr, upd_lr, upd_gr, last_row;
    logic          r_found, n_found, upd_found;
    logic [WLW-1:0] w_ext;
    logic [HLW-1:0] h_ext;
    logic          row_end, frame_end;
    logic [EXC-1:0] lc_ext, gc_ext;
    logic [EXR-1:0] lr_ext, gr_ext;

    // sizes: zero acts as one, above the maximum acts as the maximum
    always_comb begin
        w_ext = WLW'(i_width);
        h_ext = HLW'(i_height);
        if (w_ext == '0) begin
            last_col = '0;
        end else if (w_ext > WLW'(MAX_WIDTH)) begin
            last_col = CW'(MAX_WIDTH - 1);
        end else begin
            last_col = CW'(w_ext - WLW'(1));
        end
        if (h_ext == '0) begin
            last_row = '0;
        end else if (h_ext > HLW'(MAX_HEIGHT)) begin
            last_row = RW'(MAX_HEIGHT - 1);
        end else begin
            last_row = RW'(h_ext - HLW'(1));
        end
        row_end   = r_col >= last_col;
        frame_end = row_end && (r_row >= last_row);
    end

    // box including the current pixel
    always_comb begin
        upd_found = r_found;
        upd_lc    = r_lc;
        upd_gc    = r_gc;
        upd_lr    = r_lr;
        upd_gr    = r_gr;
        if (i_skin) begin
            upd_found = 1'b1;
            if (!r_found) begin
                upd_lc = r_col;
                upd_gc = r_col;
                upd_lr = r_row;
                upd_gr = r_row;
            end else begin
                if (r_col < r_lc) upd_lc = r_col;
                if (r_col > r_gc) upd_gc = r_col;
                if (r_row < r_lr) upd_lr = r_row;
                if (r_row > r_gr) upd_gr = r_row;
            end
        end
    end

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_found = r_found;
        n_lc    = r_lc;
        n_gc    = r_gc;
        n_lr    = r_lr;
        n_gr    = r_gr;
        if (i_adv) begin
            if (frame_end) begin
                n_found = 1'b0;
                n_lc    = '0;
                n_gc    = '0;
                n_lr    = '0;
                n_gr    = '0;
            end else begin
                n_found = upd_found;
                n_lc    = upd_lc;
                n_gc    = upd_gc;
                n_lr    = upd_lr;
                n_gr    = upd_gr;
            end
            if (row_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_found <= 1'b0;
            r_lc    <= '0;
            r_gc    <= '0;
            r_lr    <= '0;
            r_gr    <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_found <= n_found;
            r_lc    <= n_lc;
            r_gc    <= n_gc;
            r_lr    <= n_lr;
            r_gr    <= n_gr;
        end
    end

    always_comb begin
        lc_ext = EXC'(upd_lc);
        gc_ext = EXC'(upd_gc);
        lr_ext = EXR'(upd_lr);
        gr_ext = EXR'(upd_gr);
        o_box.frame_done = frame_end;
        o_box.box_found  = frame_end && upd_found;
        if (frame_end && upd_found) begin
            o_box.box_left   = lc_ext[BW-1:0];
            o_box.box_right  = gc_ext[BW-1:0];
            o_box.box_top    = lr_ext[BW-1:0];
            o_box.box_bottom = gr_ext[BW-1:0];
        end else begin
            o_box.box_left   = '0;
            o_box.box_right  = '0;
            o_box.box_top    = '0;
            o_box.box_bottom = '0;
        end
    end

endmodule

[hw/rtl/skin_pixel_mask_and_box.sv]
// Skin pixel mask and bounding box: top level with config registers and pipeline.
// An accepted pixel waits in the input register, then its result is registered as the result beat.
// Throughput: one pixel per cycle; while a result beat waits, the input register
// still takes one more beat, then input ready drops until the result is taken.
// Reset (synchronous, active low) empties both stages, zeroes the counters and
// the box, and loads the default frame size and chroma windows.
module skin_pixel_mask_and_box #(
    parameter int MAX_WIDTH  = spmb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = spmb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spmb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [spmb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    spmb_pix_if.sink                          i_pix,
    spmb_res_if.source                        o_res
);
    localparam int PW = spmb_pkg::PIX_W;

    logic [spmb_pkg::SIZE_W-1:0] r_width, r_height;
    spmb_pkg::t_window           r_win;
    logic                        r_in_valid, r_out_valid;
    spmb_pkg::t_pixel            r_in;
    spmb_pkg::t_result           r_out, n_out;
    logic                        adv;
    logic [PW-1:0]               cb, cr;
    logic                        skin;
    spmb_pkg::t_box_info         box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width        <= spmb_pkg::WIDTH_RST;
            r_height       <= spmb_pkg::HEIGHT_RST;
            r_win.cb_lower <= spmb_pkg::CB_LOWER_RST;
            r_win.cb_upper <= spmb_pkg::CB_UPPER_RST;
            r_win.cr_lower <= spmb_pkg::CR_LOWER_RST;
            r_win.cr_upper <= spmb_pkg::CR_UPPER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spmb_pkg::CFG_IMAGE_WIDTH:  r_width        <= i_cfg_data;
                spmb_pkg::CFG_IMAGE_HEIGHT: r_height       <= i_cfg_data;
                spmb_pkg::CFG_CB_LOWER:     r_win.cb_lower <= i_cfg_data[PW-1:0];
                spmb_pkg::CFG_CB_UPPER:     r_win.cb_upper <= i_cfg_data[PW-1:0];
                spmb_pkg::CFG_CR_LOWER:     r_win.cr_lower <= i_cfg_data[PW-1:0];
                spmb_pkg::CFG_CR_UPPER:     r_win.cr_upper <= i_cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    // the held pixel moves on whenever the result slot is free or being drained
    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pix.ready) begin
                r_in_valid <= i_pix.valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_in <= i_pix.data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    spmb_chroma u_chroma (
        .i_pix  (r_in),
        .i_win  (r_win),
        .o_cb   (cb),
        .o_cr   (cr),
        .o_skin (skin)
    );

    spmb_box #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_box (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_skin   (skin),
        .i_width  (r_width),
        .i_height (r_height),
        .o_box    (box)
    );

    always_comb begin
        n_out.masked_blue  = skin ? r_in.pixel_blue  : '0;
        n_out.masked_green = skin ? r_in.pixel_green : '0;
        n_out.masked_red   = skin ? r_in.pixel_red   : '0;
        n_out.is_skin      = skin;
        n_out.chroma_blue  = cb;
        n_out.chroma_red   = cr;
        n_out.frame_done   = box.frame_done;
        n_out.box_found    = box.box_found;
        n_out.box_left     = box.box_left;
        n_out.box_top      = box.box_top;
        n_out.box_right    = box.box_right;
        n_out.box_bottom   = box.box_bottom;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

[hw/rtl/spmb_checker.sv]
// Port-level checks for the skin pixel mask block, bound to the top level.
module spmb_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  spmb_pkg::t_result   i_res_data
);

    // box fields are only reported on the last pixel of a frame
    a_box_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_data.frame_done) |->
            (!i_res_data.box_found && i_res_data.box_left == '0 &&
             i_res_data.box_top == '0 && i_res_data.box_right == '0 &&
             i_res_data.box_bottom == '0))
        else $error("box fields set outside frame end");

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_data.box_found) |->
            (i_res_data.box_left <= i_res_data.box_right &&
             i_res_data.box_top <= i_res_data.box_bottom))
        else $error("box corners out of order");

    a_mask_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_data.is_skin) |->
            (i_res_data.masked_blue == '0 && i_res_data.masked_green == '0 &&
             i_res_data.masked_red == '0))
        else $error("non-skin pixel not masked");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result beat right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_data)))
        else $error("stalled result beat changed");

endmodule

bind skin_pixel_mask_and_box spmb_checker u_spmb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);
